// ===== design/sp2hb_pkg.sv =====
// Shared types and constants for the servo pulse to H-bridge PWM block.
// No dependencies; used by every module under design/.
package sp2hb_pkg;

  localparam int TIMER_BITS_DEF = 10;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 3;
  localparam int WIDTH_W        = 12;
  localparam int DRIVE_W        = 10;
  localparam int ZONE_W         = 10;
  localparam int TMO_W          = 8;
  localparam int EOVF_W         = 5;

  localparam logic [EOVF_W-1:0]  EDGE_OVF_CAP   = 5'd20;
  localparam logic [DRIVE_W-1:0] FULL_DRIVE     = 10'd1023;
  localparam logic [TMO_W-1:0]   BLINK_ON_BELOW = 8'd4;

  localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST   = 12'd750;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST   = 12'd2250;
  localparam logic [WIDTH_W-1:0] CENTRE_LOW_RST  = 12'd1380;
  localparam logic [WIDTH_W-1:0] CENTRE_HIGH_RST = 12'd1620;
  localparam logic [ZONE_W-1:0]  BRAKE_ZONE_RST  = 10'd50;
  localparam logic [ZONE_W-1:0]  DEAD_ZONE_RST   = 10'd70;
  localparam logic [TMO_W-1:0]   TIMEOUT_RST     = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_WIDTH   = 3'd0,
    REG_MAX_WIDTH   = 3'd1,
    REG_CENTRE_LOW  = 3'd2,
    REG_CENTRE_HIGH = 3'd3,
    REG_BRAKE_ZONE  = 3'd4,
    REG_DEAD_ZONE   = 3'd5,
    REG_TIMEOUT     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] min_width;
    logic [WIDTH_W-1:0] max_width;
    logic [WIDTH_W-1:0] centre_low;
    logic [WIDTH_W-1:0] centre_high;
    logic [ZONE_W-1:0]  brake_zone;
    logic [ZONE_W-1:0]  dead_zone;
    logic [TMO_W-1:0]   timeout;
  } cfg_t;

  typedef struct packed {
    logic               overflow;
    logic               width_ok;
    logic [WIDTH_W-1:0] width;
  } meas_t;

endpackage

// ===== design/sp2hb_cfg_regs.sv =====
// Configuration register file for the servo pulse to H-bridge PWM block.
// Depends on sp2hb_pkg.
module sp2hb_cfg_regs
  import sp2hb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_WIDTH:   cfg_nxt.min_width   = cfg_wdata;
        REG_MAX_WIDTH:   cfg_nxt.max_width   = cfg_wdata;
        REG_CENTRE_LOW:  cfg_nxt.centre_low  = cfg_wdata;
        REG_CENTRE_HIGH: cfg_nxt.centre_high = cfg_wdata;
        REG_BRAKE_ZONE:  cfg_nxt.brake_zone  = cfg_wdata[ZONE_W-1:0];
        REG_DEAD_ZONE:   cfg_nxt.dead_zone   = cfg_wdata[ZONE_W-1:0];
        REG_TIMEOUT:     cfg_nxt.timeout     = cfg_wdata[TMO_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_width   <= MIN_WIDTH_RST;
      cfg_r.max_width   <= MAX_WIDTH_RST;
      cfg_r.centre_low  <= CENTRE_LOW_RST;
      cfg_r.centre_high <= CENTRE_HIGH_RST;
      cfg_r.brake_zone  <= BRAKE_ZONE_RST;
      cfg_r.dead_zone   <= DEAD_ZONE_RST;
      cfg_r.timeout     <= TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/sp2hb_width_meas.sv =====
// Overflow detection and pulse width measurement from pin and timer polls.
// Depends on sp2hb_pkg.
module sp2hb_width_meas
  import sp2hb_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic                  level,
  input  logic [TIMER_BITS-1:0] count,
  input  cfg_t                  cfg,
  output meas_t                 meas
);

  logic                  last_level_r, last_level_nxt;
  logic [TIMER_BITS-1:0] last_count_r, last_count_nxt;
  logic [TIMER_BITS-1:0] edge_count_r, edge_count_nxt;
  logic [EOVF_W-1:0]     edge_ovf_r, edge_ovf_nxt;
  logic [EOVF_W-1:0]     edge_ovf_upd;
  logic                  overflow, rise, fall;
  logic [15:0]           diff, sum, width16;

  always_comb begin
    overflow = count < last_count_r;
    rise     = level & ~last_level_r;
    fall     = ~level & last_level_r;
    if (overflow && (edge_ovf_r < EDGE_OVF_CAP)) begin
      edge_ovf_upd = edge_ovf_r + EOVF_W'(1);
    end else if (overflow) begin
      edge_ovf_upd = EDGE_OVF_CAP;
    end else begin
      edge_ovf_upd = edge_ovf_r;
    end
    diff    = 16'(count) - 16'(edge_count_r);
    sum     = diff + (16'(edge_ovf_upd) << TIMER_BITS);
    width16 = {sum[14:0], 1'b0};

    meas.overflow = overflow;
    meas.width_ok = fall && (width16 >= 16'(cfg.min_width)) &&
                    (width16 <= 16'(cfg.max_width));
    meas.width    = width16[WIDTH_W-1:0];

    last_level_nxt = level;
    last_count_nxt = count;
    edge_count_nxt = rise ? count : edge_count_r;
    edge_ovf_nxt   = rise ? '0 : edge_ovf_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      last_count_r <= '0;
      edge_count_r <= '0;
      edge_ovf_r   <= '0;
    end else if (step) begin
      last_level_r <= last_level_nxt;
      last_count_r <= last_count_nxt;
      edge_count_r <= edge_count_nxt;
      edge_ovf_r   <= edge_ovf_nxt;
    end
  end

  a_edge_ovf_capped: assert property (@(posedge clk) disable iff (!rst_n)
    edge_ovf_r <= EDGE_OVF_CAP)
    else $error("edge overflow count above cap");

endmodule

// ===== design/sp2hb_drive_ctrl.sv =====
// Timeout, LED blink, centre capture and drive level mapping.
// Depends on sp2hb_pkg; fed by sp2hb_width_meas.
module sp2hb_drive_ctrl
  import sp2hb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  meas_t              meas,
  input  cfg_t               cfg,
  output logic [DRIVE_W-1:0] drive_a,
  output logic [DRIVE_W-1:0] drive_b,
  output logic               led
);

  logic [TMO_W-1:0]   idle_r, idle_nxt;
  logic [TMO_W-1:0]   blink_r, blink_nxt;
  logic               centre_known_r, centre_known_nxt;
  logic [WIDTH_W-1:0] centre_r, centre_nxt;
  logic [DRIVE_W-1:0] drive_a_r, drive_a_nxt;
  logic [DRIVE_W-1:0] drive_b_r, drive_b_nxt;
  logic               led_r, led_nxt;

  logic [TMO_W:0]     idle_inc;
  logic               timeout_hit;
  logic               neg, brake, active;
  logic [WIDTH_W-1:0] mag, excess;
  logic [WIDTH_W+1:0] scaled;
  logic [DRIVE_W-1:0] level;

  always_comb begin
    idle_inc    = {1'b0, idle_r} + (TMO_W+1)'(1);
    timeout_hit = meas.overflow && (idle_inc >= {1'b0, cfg.timeout});

    idle_nxt         = idle_r;
    blink_nxt        = blink_r;
    centre_known_nxt = centre_known_r;
    centre_nxt       = centre_r;
    drive_a_nxt      = drive_a_r;
    drive_b_nxt      = drive_b_r;
    led_nxt          = led_r;

    if (meas.overflow) begin
      idle_nxt = timeout_hit ? cfg.timeout : idle_inc[TMO_W-1:0];
    end
    if (timeout_hit) begin
      blink_nxt   = blink_r + TMO_W'(1);
      drive_a_nxt = '0;
      drive_b_nxt = '0;
      led_nxt     = blink_nxt < BLINK_ON_BELOW;
    end

    neg    = meas.width < centre_r;
    mag    = neg ? centre_r - meas.width : meas.width - centre_r;
    brake  = mag < WIDTH_W'(cfg.brake_zone);
    active = mag > WIDTH_W'(cfg.dead_zone);
    excess = mag - WIDTH_W'(cfg.dead_zone);
    scaled = {1'b0, excess, 1'b0} + (WIDTH_W+2)'(excess);
    level  = (scaled > (WIDTH_W+2)'(FULL_DRIVE)) ? FULL_DRIVE : scaled[DRIVE_W-1:0];

    if (meas.width_ok) begin
      idle_nxt = '0;
      if (!centre_known_r) begin
        if ((meas.width > cfg.centre_low) && (meas.width < cfg.centre_high)) begin
          centre_nxt       = meas.width;
          centre_known_nxt = 1'b1;
        end
      end else begin
        led_nxt = 1'b1;
        if (brake) begin
          drive_a_nxt = FULL_DRIVE;
          drive_b_nxt = FULL_DRIVE;
        end else if (active) begin
          drive_a_nxt = neg ? '0 : level;
          drive_b_nxt = neg ? level : '0;
        end else begin
          drive_a_nxt = '0;
          drive_b_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r         <= '0;
      blink_r        <= '0;
      centre_known_r <= 1'b0;
      centre_r       <= '0;
      drive_a_r      <= '0;
      drive_b_r      <= '0;
      led_r          <= 1'b0;
    end else if (step) begin
      idle_r         <= idle_nxt;
      blink_r        <= blink_nxt;
      centre_known_r <= centre_known_nxt;
      centre_r       <= centre_nxt;
      drive_a_r      <= drive_a_nxt;
      drive_b_r      <= drive_b_nxt;
      led_r          <= led_nxt;
    end
  end

  assign drive_a = drive_a_r;
  assign drive_b = drive_b_r;
  assign led     = led_r;

  a_both_on_is_brake: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_a_r != '0) && (drive_b_r != '0) |->
      (drive_a_r == FULL_DRIVE) && (drive_b_r == FULL_DRIVE))
    else $error("both drives on without full brake");

  a_drive_implies_led: assert property (@(posedge clk) disable iff (!rst_n)
    (drive_a_r != '0) || (drive_b_r != '0) |-> led_r)
    else $error("drive active with LED off");

  a_centre_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    centre_known_r |=> centre_known_r)
    else $error("centre lost after capture");

endmodule

// ===== design/servo_pulse_to_hbridge_pwm_top.sv =====
// Top level of the servo pulse to H-bridge PWM block: request register,
// result handshake and the three submodules. Depends on sp2hb_pkg.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid/in_ready   | in_pin_level, in_timer_count
//   out     | output    | out_valid/out_ready | out_drive_a, out_drive_b, out_led
//   cfg     | input     | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready is high; each request's result
// appears when the drive and LED registers load from the request register.
// The measurement and drive state registers update together on each step, which sets the rate.
// Synchronous active-low reset clears all state but the request payload and loads register defaults.
// A stalled result holds; one more request may wait in the request register.
module servo_pulse_to_hbridge_pwm_top
  import sp2hb_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pin_level,
  input  logic [TIMER_BITS-1:0] in_timer_count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DRIVE_W-1:0]    out_drive_a,
  output logic [DRIVE_W-1:0]    out_drive_b,
  output logic                  out_led,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  logic                  req_v_r, req_v_nxt;
  logic                  req_level_r;
  logic [TIMER_BITS-1:0] req_count_r;
  logic                  out_valid_r, out_valid_nxt;
  logic                  step;
  cfg_t                  cfg;
  meas_t                 meas;

  assign step     = req_v_r && (!out_valid_r || out_ready);
  assign in_ready = !req_v_r || step;

  always_comb begin
    req_v_nxt = req_v_r;
    if (in_valid && in_ready) begin
      req_v_nxt = 1'b1;
    end else if (step) begin
      req_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      req_v_r     <= req_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_level_r <= in_pin_level;
      req_count_r <= in_timer_count;
    end
  end

  sp2hb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sp2hb_width_meas #(
    .TIMER_BITS (TIMER_BITS)
  ) u_meas (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .level (req_level_r),
    .count (req_count_r),
    .cfg   (cfg),
    .meas  (meas)
  );

  sp2hb_drive_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .meas    (meas),
    .cfg     (cfg),
    .drive_a (out_drive_a),
    .drive_b (out_drive_b),
    .led     (out_led)
  );

  assign out_valid = out_valid_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> req_v_r && out_valid_r && !out_ready)
    else $error("request side stalled with room downstream");

endmodule
